// ===== src/knc_pkg.sv =====
`default_nettype none
package knc_pkg;

  localparam int unsigned OUT_FRAC_BITS = 28;
  localparam int unsigned ROOT_BITS     = 32;
  // wide datapath of the root/divide chain; holds a2 << (2*OUT_FRAC_BITS) for the top setting
  localparam int unsigned WIDE_W        = 128;
  // quotient floor test: a2 << 2F > p << 62  <=>  a2 > p << (62 - 2F)
  localparam int unsigned SAT_SHIFT     = 62 - 2 * OUT_FRAC_BITS;

  localparam logic [31:0] FIX_ONE   = 32'(64'd1 << OUT_FRAC_BITS);
  localparam logic [31:0] FIX_ZERO  = 32'd0;
  localparam logic [31:0] FIX_FLOOR = 32'h8000_0000;

  typedef struct packed {
    logic [WIDE_W-1:0]    rem;   // N - t^2 * p
    logic [WIDE_W-1:0]    pb;    // p << 2b for the current bit
    logic [WIDE_W-1:0]    zb;    // t * p << (b + 1)
    logic [ROOT_BITS-1:0] root;  // t, bits decided so far
    logic                 neg;
    logic                 bypass;
    logic [31:0]          bnorm;
    logic                 fb;
    logic                 sat;
  } knc_work_t;

endpackage : knc_pkg
`default_nettype wire

// ===== src/knc_cell.sv =====
`default_nettype none
module knc_cell
  import knc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire knc_work_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output knc_work_t      out_data_o
);

  logic              valid_q;
  knc_work_t         data_q, data_d;
  logic [WIDE_W-1:0] step;
  logic              take;

  // one root bit: try (t|1)^2 * p against the remaining numerator
  always_comb begin
    data_d = in_data_i;
    step   = in_data_i.pb + in_data_i.zb;
    take   = (in_data_i.rem >= step);
    if (take) begin
      data_d.rem = in_data_i.rem - step;
      data_d.zb  = in_data_i.zb + (in_data_i.pb << 1);
    end
    data_d.zb   = data_d.zb >> 1;
    data_d.pb   = in_data_i.pb >> 2;
    data_d.root = {in_data_i.root[ROOT_BITS-2:0], take};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule : knc_cell
`default_nettype wire

// ===== src/kernel_cell_normalizer_core.sv =====
`default_nettype none
// Cosine normalisation of kernel matrix cells: cross / sqrt(row_self * col_self).
// Input channel: in_valid_i / in_ready_o with cross_value_i, row_self_i, col_self_i
// (signed Q16.16) and on_diagonal_i. Output channel: out_valid_o / out_ready_i with
// normalized_o (signed Q4.28), fallback_used_o and saturated_o; one result per item.
// Each beat passes through 35 registers: an input register, a multiply stage
// (products r*s and c*c), a row of 32 root cells, one per result bit, each doing
// one wide add, compare and subtract, and an output register.
// Throughput is one beat per cycle without stalls; every stage holds its own valid bit, so
// bubbles collapse and a new beat is accepted while a result waits at the output.
// When the receiver stalls the pipeline fills up and in_ready_o drops once every
// stage holds a beat. Reset clears all valid bits; no results are pending after it.
module kernel_cell_normalizer_core
  import knc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] cross_value_i,
  input  wire logic [31:0] row_self_i,
  input  wire logic [31:0] col_self_i,
  input  wire logic        on_diagonal_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      normalized_o,
  output logic             fallback_used_o,
  output logic             saturated_o
);

  // stage 1: raw inputs
  logic        s1_valid_q, s1_ready;
  logic [31:0] c_q, r_q, s_q;
  logic        diag_q;

  // stage 2: products and early cases
  logic        s2_valid_q, s2_ready;
  logic [61:0] p_q;
  logic [63:0] a2_q;
  logic        neg_q, pos_q, diag2_q, early_q, early_fb_q;
  logic [31:0] early_norm_q;

  logic        early_d, early_fb_d;
  logic [31:0] early_norm_d;
  logic [31:0] abs_c;

  knc_work_t   chain_data [ROOT_BITS+1];
  logic        chain_valid [ROOT_BITS+1];
  logic        chain_ready [ROOT_BITS+1];

  logic        out_valid_q, out_ready;
  logic [31:0] norm_q;
  logic        fb_q, sat_q;

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      c_q    <= cross_value_i;
      r_q    <= row_self_i;
      s_q    <= col_self_i;
      diag_q <= on_diagonal_i;
    end
  end

  always_comb begin
    abs_c        = c_q[31] ? (32'd0 - c_q) : c_q;
    early_d      = 1'b1;
    early_fb_d   = 1'b0;
    early_norm_d = FIX_ZERO;
    if (r_q == 32'd0 && s_q == 32'd0) begin
      early_norm_d = FIX_ONE;
    end else if (r_q == 32'd0 || s_q == 32'd0) begin
      early_norm_d = FIX_ZERO;
    end else if (r_q[31] || s_q[31]) begin
      early_norm_d = diag_q ? FIX_ONE : FIX_ZERO;
      early_fb_d   = 1'b1;
    end else begin
      early_d = 1'b0;
    end
  end

  assign s2_ready = !s2_valid_q || chain_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      p_q          <= r_q[30:0] * s_q[30:0];
      a2_q         <= abs_c * abs_c;
      neg_q        <= c_q[31];
      pos_q        <= !c_q[31] && (c_q != 32'd0);
      diag2_q      <= diag_q;
      early_q      <= early_d;
      early_fb_q   <= early_fb_d;
      early_norm_q <= early_norm_d;
    end
  end

  // classification and chain seed
  always_comb begin
    logic [WIDE_W-1:0] a2_w, p_w;
    a2_w = {{(WIDE_W-64){1'b0}}, a2_q};
    p_w  = {{(WIDE_W-62){1'b0}}, p_q};
    chain_data[0].rem    = a2_w << (2 * OUT_FRAC_BITS);
    chain_data[0].pb     = p_w << (2 * (ROOT_BITS - 1));
    chain_data[0].zb     = '0;
    chain_data[0].root   = '0;
    chain_data[0].neg    = neg_q;
    chain_data[0].bypass = 1'b1;
    chain_data[0].bnorm  = early_norm_q;
    chain_data[0].fb     = early_fb_q;
    chain_data[0].sat    = 1'b0;
    if (early_q) begin
      chain_data[0].bypass = 1'b1;
    end else if (pos_q && (a2_w > p_w)) begin
      chain_data[0].bnorm = diag2_q ? FIX_ONE : FIX_ZERO;
      chain_data[0].fb    = 1'b1;
    end else if (neg_q && (a2_w > (p_w << SAT_SHIFT))) begin
      chain_data[0].bnorm = FIX_FLOOR;
      chain_data[0].sat   = 1'b1;
    end else begin
      chain_data[0].bypass = 1'b0;
    end
  end
  assign chain_valid[0] = s2_valid_q;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
    knc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  assign out_ready              = !out_valid_q || out_ready_i;
  assign chain_ready[ROOT_BITS] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= chain_valid[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && chain_valid[ROOT_BITS]) begin
      if (chain_data[ROOT_BITS].bypass) begin
        norm_q <= chain_data[ROOT_BITS].bnorm;
      end else if (chain_data[ROOT_BITS].neg) begin
        norm_q <= 32'd0 - chain_data[ROOT_BITS].root;
      end else begin
        norm_q <= chain_data[ROOT_BITS].root;
      end
      fb_q  <= chain_data[ROOT_BITS].fb;
      sat_q <= chain_data[ROOT_BITS].sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign normalized_o    = norm_q;
  assign fallback_used_o = fb_q;
  assign saturated_o     = sat_q;

`ifndef ASSERT_OFF
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(saturated_o && fallback_used_o))
    else $error("fallback and saturation flagged on one beat");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (normalized_o == FIX_FLOOR))
    else $error("saturated beat not at floor");

  a_fb_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fallback_used_o) |-> (normalized_o == FIX_ONE || normalized_o == FIX_ZERO))
    else $error("fallback beat neither one nor zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(normalized_o)))
    else $error("stalled result changed");
`endif

endmodule : kernel_cell_normalizer_core
`default_nettype wire

// ===== sim/tb_kernel_cell_normalizer_core.sv =====
`timescale 1ns / 100ps
module tb_kernel_cell_normalizer_core;
  import knc_pkg::*;

  localparam int unsigned IN_FRAC  = 16;
  localparam int unsigned LATENCY  = 35;
  localparam longint     CYCLE_CAP = 400000;

  typedef struct packed {
    logic [31:0] norm;
    logic        fb;
    logic        sat;
  } cell_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] cross_value_i = '0;
  logic [31:0] row_self_i = '0;
  logic [31:0] col_self_i = '0;
  logic        on_diagonal_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] normalized_o;
  logic        fallback_used_o;
  logic        saturated_o;

  cell_res_t   pending_q[$];
  int          errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off = 1'b0;
  longint      cycles = 0;

  kernel_cell_normalizer_core u_dut (.*);

  always #4 clk_i = ~clk_i;

  // exact integer square root of a 128-bit value (root fits 32 bits here)
  function automatic logic [31:0] isqrt_wide(logic [127:0] v);
    logic [31:0]  t;
    logic [63:0]  cand;
    t = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = {32'd0, t | (32'd1 << b)};
      if ({64'd0, cand * cand} <= v) t = t | (32'd1 << b);
    end
    return t;
  endfunction

  function automatic cell_res_t cosine_norm(logic [31:0] c_raw, logic [31:0] r_raw,
                                            logic [31:0] s_raw, logic diag);
    cell_res_t    res;
    longint       c, r, s;
    logic [63:0]  p, a, a2;
    logic [127:0] num;
    c = longint'($signed(c_raw));
    r = longint'($signed(r_raw));
    s = longint'($signed(s_raw));
    res = '{norm: FIX_ZERO, fb: 1'b0, sat: 1'b0};
    if (r == 0 && s == 0) begin
      res.norm = FIX_ONE;
    end else if (r == 0 || s == 0) begin
      res.norm = FIX_ZERO;
    end else if (r < 0 || s < 0) begin
      res.norm = diag ? FIX_ONE : FIX_ZERO;
      res.fb   = 1'b1;
    end else begin
      p  = 64'(r) * 64'(s);
      a  = (c < 0) ? 64'(-c) : 64'(c);
      a2 = a * a;
      if (c > 0 && a2 > p) begin
        res.norm = diag ? FIX_ONE : FIX_ZERO;
        res.fb   = 1'b1;
      end else begin
        num = {64'd0, a2} << (2 * OUT_FRAC_BITS);
        if (c < 0 && num > ({64'd0, p} << 62)) begin
          res.norm = FIX_FLOOR;
          res.sat  = 1'b1;
        end else begin
          res.norm = isqrt_wide(num / {64'd0, p});
          if (c < 0) res.norm = -res.norm;
        end
      end
    end
    return res;
  endfunction

  // valid stays up between back-to-back beats; it drops only in idle cycles and in drain
  task automatic send_cell(logic [31:0] c, logic [31:0] r, logic [31:0] s, logic d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cross_value_i <= c;
    row_self_i    <= r;
    col_self_i    <= s;
    on_diagonal_i <= d;
    pending_q.push_back(cosine_norm(c, r, s, d));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000);
      2: return 32'h0001_0000 + $urandom_range(0, 32'h0000_ffff);
      3: return -$urandom_range(0, 32'h0010_0000);
      4: return $urandom_range(1, 4);
      default: return 32'($urandom_range(1, 32'h7fff_ffff));
    endcase
  endfunction

  // mostly positive self values (some random words or zero) with a cross value often near the quotient limits
  task automatic send_random_cell();
    logic [31:0] r, s, c;
    r = $urandom_range(9) == 0 ? rand_word() : $urandom_range(1, 32'h7fff_ffff);
    s = $urandom_range(9) == 0 ? rand_word() : $urandom_range(1, 32'h7fff_ffff);
    case ($urandom_range(4))
      0: c = rand_word();
      1: c = $urandom_range(0, 32'h7fff_ffff) >> $urandom_range(31);
      2: c = -($urandom_range(0, 32'h7fff_ffff) >> $urandom_range(31));
      3: c = $urandom_range(9) < 5 ? r : s;
      default: c = -((r >> $urandom_range(1, 4)) + $urandom_range(3));
    endcase
    if ($urandom_range(49) == 0) r = 0;
    if ($urandom_range(49) == 0) s = 0;
    send_cell(c, r, s, 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic test_corner_cells();
    logic [31:0] one_in;
    one_in = 32'd1 << IN_FRAC;
    send_cell(one_in, 32'd0, 32'd0, 1'b0);
    send_cell(32'h8000_0000, 32'd0, 32'h8000_0000, 1'b1);
    send_cell(one_in, 32'hffff_ffff, 32'd0, 1'b1);
    send_cell(one_in, 32'hffff_0000, one_in, 1'b1);
    send_cell(one_in, one_in, 32'h8000_0000, 1'b0);
    send_cell(32'h0001_0001, one_in, one_in, 1'b1);
    send_cell(32'h7fff_ffff, 32'd1, 32'd1, 1'b0);
    send_cell(one_in, one_in, one_in, 1'b0);
    send_cell(-one_in, one_in, one_in, 1'b1);
    send_cell(32'h8000_0000, 32'd1, 32'd1, 1'b0);
    send_cell(-32'd8, 32'd1, 32'd1, 1'b0);
    send_cell(-32'd9, 32'd1, 32'd1, 1'b1);
    send_cell(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_cell(32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_cell(32'd0, 32'd3, 32'd5, 1'b1);
    send_cell(32'hffff_ffff, 32'h7fff_ffff, 32'd1, 1'b0);
    send_cell(32'd3, 32'd2, 32'd8, 1'b0);
    drain();
  endtask

  task automatic test_random_cells(int n, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_random_cell();
    drain();
  endtask

  // receiver stalls long enough for the pipeline to fill and back up
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    repeat (80) send_random_cell();
    drain();
  endtask

  always @(posedge clk_i) begin : hold_off_timer
    int cnt;
    if (hold_off) begin
      cnt = cnt + 1;
      if (cnt >= 200) begin
        hold_off <= 1'b0;
        cnt = 0;
      end
    end else begin
      cnt = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni)
      out_ready_i <= !hold_off && !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    cell_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat norm=%h fb=%b sat=%b", $time, normalized_o,
                 fallback_used_o, saturated_o);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        if (normalized_o !== exp_res.norm) begin
          $display("%0t: normalized exp %h got %h", $time, exp_res.norm, normalized_o);
          errors++;
        end
        if (fallback_used_o !== exp_res.fb) begin
          $display("%0t: fallback_used exp %b got %b", $time, exp_res.fb, fallback_used_o);
          errors++;
        end
        if (saturated_o !== exp_res.sat) begin
          $display("%0t: saturated exp %b got %b", $time, exp_res.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("kernel_cell_normalizer_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cells();
    test_random_cells(620, 15, 88);
    test_random_cells(620, 88, 15);
    test_back_pressure();
    test_random_cells(600, 0, 0);
    if (errors == 0 && pending_q.size() == 0)
      $display("kernel_cell_normalizer_core: match");
    else
      $display("kernel_cell_normalizer_core: mismatch");
    $finish;
  end

endmodule
